// ----- rtl/rpt_pkg.sv -----
// Package for the replication progress tracker.
// Holds the word types, operation and mode codes and window sizing constants.
// No dependencies.
`default_nettype none
package rpt_pkg;
  localparam int WINDOW_DEPTH = 256;
  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [3:0] {
    OP_ACK = 4'd0, OP_REJECT = 4'd1, OP_TO_PROBE = 4'd2, OP_TO_REPLICATE = 4'd3,
    OP_TO_SNAPSHOT = 4'd4, OP_SENT = 4'd5, OP_FREE_TO = 4'd6, OP_FREE_FIRST = 4'd7,
    OP_PAUSE = 4'd8
  } op_t;

  localparam logic [1:0] MODE_PROBE = 2'd0;
  localparam logic [1:0] MODE_REPLICATE = 2'd1;
  localparam logic [1:0] MODE_SNAPSHOT = 2'd2;

  typedef struct packed {
    logic [3:0]  operation;
    logic [62:0] log_index;
    logic [62:0] follower_last;
  } in_word_t;

  typedef struct packed {
    logic        accepted;
    logic [63:0] next_out;
    logic [62:0] match_out;
    logic [1:0]  mode_out;
    logic        sending_paused;
    logic        snapshot_abort;
    logic [8:0]  window_fill;
    logic        window_overflow;
  } out_word_t;

  // Classified event handed from the front part to the back part.
  typedef struct packed {
    logic [3:0]  operation;
    logic [62:0] log_index;
    logic [63:0] last_plus1;
    logic        op_known;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_READ, ST_WAITRD, ST_CHECK, ST_OUT
  } state_t;
endpackage
`default_nettype wire

// ----- rtl/rpt_front.sv -----
// Front part: accepts input words and queues classified events.
// Depends on rpt_pkg.
`default_nettype none
module rpt_front (
  input  wire              clk,
  input  wire              rst,
  input  rpt_pkg::in_word_t in_data,
  input  wire              in_valid,
  output logic             in_ready,
  output rpt_pkg::cmd_t    cmd,
  output logic             cmd_valid,
  input  wire              cmd_take
);
  import rpt_pkg::*;

  // Two-entry queue.
  cmd_t q [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  cmd_t c;

  always_comb begin
    c.operation = in_data.operation;
    c.log_index = in_data.log_index;
    c.last_plus1 = {1'b0, in_data.follower_last} + 64'd1;
    c.op_known = (in_data.operation <= 4'd8);
  end

  assign in_ready = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) q[wr_ptr] <= c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= ~wr_ptr;
      if (cmd_take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, in_valid && in_ready} - {1'b0, cmd_take};
    end
  end

`ifndef NO_ASSERTIONS
  a_take_valid: assert property (@(posedge clk) disable iff (rst) cmd_take |-> cmd_valid)
    else $error("queue read while empty");
  a_count: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  a_full: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !cmd_take) |=> !in_ready)
    else $error("full queue took a word");
`endif
endmodule
`default_nettype wire

// ----- rtl/rpt_back.sv -----
// Back part: executes events on the tracker state and the in-flight window.
// Depends on rpt_pkg.
`default_nettype none
module rpt_back (
  input  wire               clk,
  input  wire               rst,
  input  rpt_pkg::cmd_t     cmd,
  input  wire               cmd_valid,
  output logic              cmd_take,
  input  wire  [8:0]        limit_reg,
  output rpt_pkg::out_word_t out_data,
  output logic              out_valid,
  input  wire               out_ready
);
  import rpt_pkg::*;

  logic [63:0] mem [WINDOW_DEPTH];
  logic [63:0] rd_data;
  logic [SLOT_W-1:0] rd_addr;
  logic rd_en;

  logic [SLOT_W-1:0] head, head_next, scan, scan_next;
  logic [FILL_W-1:0] used, used_next, n, n_next;
  logic [63:0] next_index, next_index_next, match_index, match_index_next;
  logic [63:0] pend, pend_next;
  logic [1:0] mode, mode_next;
  logic paused, paused_next;
  logic [63:0] to_val, to_val_next;
  logic first, first_next;
  logic accepted, accepted_next, ovf, ovf_next;
  state_t state, state_next;
  logic wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [FILL_W-1:0] limit_eff;
  logic full;
  logic [63:0] idx64, m1, p1;
  logic [FILL_W:0] slot_sum;

  always_comb begin
    if (limit_reg == 9'd0) limit_eff = FILL_W'(1);
    else if ({{(32-9){1'b0}}, limit_reg} > WINDOW_DEPTH) limit_eff = FILL_W'(WINDOW_DEPTH);
    else limit_eff = FILL_W'(limit_reg);
  end
  assign full = (used >= limit_eff);
  assign idx64 = {1'b0, cmd.log_index};
  assign m1 = match_index + 64'd1;
  assign p1 = pend + 64'd1;
  assign slot_sum = {1'b0, {(FILL_W - SLOT_W){1'b0}}, head} + {1'b0, used};

  // Window memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= idx64;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head <= '0;
      used <= '0;
      next_index <= 64'd1;
      match_index <= '0;
      pend <= '0;
      mode <= MODE_PROBE;
      paused <= 1'b0;
    end else begin
      state <= state_next;
      head <= head_next;
      used <= used_next;
      next_index <= next_index_next;
      match_index <= match_index_next;
      pend <= pend_next;
      mode <= mode_next;
      paused <= paused_next;
    end
    scan <= scan_next;
    n <= n_next;
    to_val <= to_val_next;
    first <= first_next;
    accepted <= accepted_next;
    ovf <= ovf_next;
  end

  // Event sequencer.
  always_comb begin
    state_next = state;
    head_next = head; used_next = used; next_index_next = next_index;
    match_index_next = match_index; pend_next = pend; mode_next = mode;
    paused_next = paused; scan_next = scan; n_next = n; to_val_next = to_val;
    first_next = first; accepted_next = accepted; ovf_next = ovf;
    cmd_take = 1'b0; wr_en = 1'b0; rd_en = 1'b0; rd_addr = scan;
    wr_addr = slot_sum >= (FILL_W+1)'(WINDOW_DEPTH) ?
              SLOT_W'(slot_sum - (FILL_W+1)'(WINDOW_DEPTH)) : SLOT_W'(slot_sum);
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_take = 1'b1;
        accepted_next = 1'b0;
        ovf_next = 1'b0;
        state_next = ST_OUT;
        case (cmd.operation)
          OP_ACK: begin
            if (match_index < idx64) begin
              match_index_next = idx64; accepted_next = 1'b1; paused_next = 1'b0;
            end
            if (next_index < idx64 + 64'd1) next_index_next = idx64 + 64'd1;
          end
          OP_REJECT: begin
            if (mode == MODE_REPLICATE) begin
              if (idx64 > match_index) begin
                next_index_next = m1; accepted_next = 1'b1;
              end
            end else if (next_index - 64'd1 == idx64) begin
              if (idx64 < cmd.last_plus1)
                next_index_next = (idx64 == 64'd0) ? 64'd1 : idx64;
              else next_index_next = cmd.last_plus1;
              paused_next = 1'b0; accepted_next = 1'b1;
            end
          end
          OP_TO_PROBE, OP_TO_REPLICATE, OP_TO_SNAPSHOT: begin
            paused_next = 1'b0; pend_next = '0; head_next = '0; used_next = '0;
            if (cmd.operation == OP_TO_PROBE) begin
              mode_next = MODE_PROBE;
              next_index_next = (mode == MODE_SNAPSHOT && p1 > m1) ? p1 : m1;
            end else if (cmd.operation == OP_TO_REPLICATE) begin
              mode_next = MODE_REPLICATE; next_index_next = m1;
            end else begin
              mode_next = MODE_SNAPSHOT; pend_next = idx64;
            end
          end
          OP_SENT: begin
            if (full) ovf_next = 1'b1;
            else begin
              wr_en = 1'b1; used_next = used + FILL_W'(1);
            end
          end
          OP_FREE_TO, OP_FREE_FIRST: begin
            if (used != '0) begin
              to_val_next = idx64;
              // The queue entry is released here, so the kind of free is kept.
              first_next = (cmd.operation == OP_FREE_FIRST);
              scan_next = head;
              n_next = '0;
              state_next = ST_READ;
            end
          end
          OP_PAUSE: paused_next = 1'b1;
          default: ;
        endcase
      end
      ST_READ: begin
        rd_en = 1'b1;
        state_next = ST_WAITRD;
      end
      ST_WAITRD: state_next = ST_CHECK;
      ST_CHECK: begin
        // The first entry read fixes the bound for free_first and checks free_to.
        if (first) begin
          to_val_next = rd_data; first_next = 1'b0;
          n_next = n + FILL_W'(1);
          scan_next = (scan == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : scan + SLOT_W'(1);
          if (n + FILL_W'(1) < used) state_next = ST_READ;
          else begin
            used_next = '0; head_next = '0; state_next = ST_OUT;
          end
        end else if (rd_data <= to_val) begin
          first_next = 1'b0;
          n_next = n + FILL_W'(1);
          scan_next = (scan == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : scan + SLOT_W'(1);
          if (n + FILL_W'(1) < used) state_next = ST_READ;
          else begin
            used_next = '0; head_next = '0; state_next = ST_OUT;
          end
        end else begin
          used_next = used - n;
          head_next = (used == n) ? '0 : scan;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_data.accepted = accepted;
    out_data.next_out = next_index;
    out_data.match_out = match_index[62:0];
    out_data.mode_out = mode;
    if (mode == MODE_PROBE) out_data.sending_paused = paused;
    else if (mode == MODE_REPLICATE) out_data.sending_paused = full;
    else out_data.sending_paused = 1'b1;
    out_data.snapshot_abort = (mode == MODE_SNAPSHOT) && (match_index >= pend);
    out_data.window_fill = 9'(used);
    out_data.window_overflow = ovf;
  end

`ifndef NO_ASSERTIONS
  a_used: assert property (@(posedge clk) disable iff (rst) used <= FILL_W'(WINDOW_DEPTH))
    else $error("window fill beyond depth");
  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && used == '0) |-> head == '0)
    else $error("empty window with nonzero head");
  a_take: assert property (@(posedge clk) disable iff (rst) cmd_take |-> state == ST_EXEC)
    else $error("event taken outside execute");
`endif
endmodule
`default_nettype wire

// ----- rtl/replication_progress_tracker_top.sv -----
// Top level of the replication progress tracker.
// Depends on rpt_pkg, rpt_front and rpt_back.
`default_nettype none
// Leader-side progress tracker for one follower. Each input word is one event and
// gives one result word. Most events pass from the queue through the idle and
// execute states to a waiting result; free_to and free_first walk the window
// memory through its registered read port, with a read, a wait and a check state
// for each entry examined. A two-entry queue lets input words be taken while a
// result waits. The window_limit register is written through the cfg channel; no
// clearing pass is needed after reset.
module replication_progress_tracker_top (
  input  wire               clk,
  input  wire               rst,
  input  rpt_pkg::in_word_t in_data,
  input  wire               in_valid,
  output logic              in_ready,
  output rpt_pkg::out_word_t out_data,
  output logic              out_valid,
  input  wire               out_ready,
  input  wire  [8:0]        cfg_data,
  input  wire               cfg_valid,
  output logic              cfg_ready
);
  import rpt_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_take;
  logic [8:0] limit_reg;

  // Window limit register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) limit_reg <= 9'd256;
    else if (cfg_valid) limit_reg <= cfg_data;
  end

  rpt_front u_front (
    .clk(clk), .rst(rst), .in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
  );

  rpt_back u_back (
    .clk(clk), .rst(rst), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
    .limit_reg(limit_reg), .out_data(out_data), .out_valid(out_valid),
    .out_ready(out_ready)
  );
endmodule
`default_nettype wire
